FILE: rtl/core/bmpfb_pkg.sv
package bmpfb_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;
    localparam int HEADER_BYTES  = 54;

    // header byte positions of the little-endian width and height words
    localparam int WIDTH_LO  = 18;
    localparam int HEIGHT_LO = 22;

    localparam int HDR_CNT_W = $clog2(HEADER_BYTES);
    localparam int COL_W     = $clog2(SCREEN_WIDTH + 1);
    localparam int ROW_W     = $clog2(SCREEN_HEIGHT + 1);
    localparam int DIM_W     = 32;
    localparam int CHK_W     = DIM_W + 2;

    localparam int BYTE_W  = 8;
    localparam int XOFF_W  = 10;
    localparam int YOFF_W  = 9;
    localparam int ADDR_W  = 19;
    localparam int COLOR_W = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 2'd1;

    localparam logic RK_PIXEL = 1'b0;
    localparam logic RK_RANGE = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_PIXELS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        TRIP_BLUE  = 3'b001,
        TRIP_GREEN = 3'b010,
        TRIP_RED   = 3'b100
    } triple_t;

    typedef struct packed {
        logic [BYTE_W-1:0] file_byte;
        logic              file_start;
    } in_item_t;

    typedef struct packed {
        logic               result_kind;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
    } out_item_t;

    typedef struct packed {
        logic [XOFF_W-1:0] x_offset;
        logic [YOFF_W-1:0] y_offset;
    } offsets_t;

endpackage

FILE: rtl/core/bmp24_framebuffer_blitter_unit.sv
// a byte accepted is held in the input register; its request, if it makes one,
// moves into the result register once that register is free, which raises m_valid
// throughput: one byte per cycle; ready stays high while the input register is
// empty or the result register is empty or being taken
// reset (aresetn low, synchronous): parser idle until a file start, offsets zero
module bmp24_framebuffer_blitter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bmpfb_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bmpfb_pkg::out_item_t                m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmpfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmpfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bmpfb_pkg::offsets_t  offsets;
    bmpfb_pkg::in_item_t  in_data_reg;
    bmpfb_pkg::out_item_t out_data_reg, res;
    logic                 in_valid_reg, in_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free, step, res_valid;

    assign cfg_ready = 1'b1;

    bmpfb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .offsets   (offsets)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    bmpfb_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_data_reg),
        .offsets   (offsets),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: rtl/core/bmpfb_cfg.sv
module bmpfb_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [bmpfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmpfb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output bmpfb_pkg::offsets_t                 offsets
);

    logic [bmpfb_pkg::XOFF_W-1:0] x_offset_reg;
    logic [bmpfb_pkg::YOFF_W-1:0] y_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_offset_reg <= '0;
            y_offset_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bmpfb_pkg::CFG_X_OFFSET: begin
                    x_offset_reg <= cfg_data[bmpfb_pkg::XOFF_W-1:0];
                end
                bmpfb_pkg::CFG_Y_OFFSET: begin
                    y_offset_reg <= cfg_data[bmpfb_pkg::YOFF_W-1:0];
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    assign offsets.x_offset = x_offset_reg;
    assign offsets.y_offset = y_offset_reg;

endmodule

FILE: rtl/core/bmpfb_core.sv
module bmpfb_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  bmpfb_pkg::in_item_t    item,
    input  bmpfb_pkg::offsets_t    offsets,
    output logic                   res_valid,
    output bmpfb_pkg::out_item_t   res
);

    bmpfb_pkg::phase_t  phase_reg, phase_next, cur_phase;
    bmpfb_pkg::triple_t trip_reg, trip_next, cur_trip;

    logic [bmpfb_pkg::HDR_CNT_W-1:0] cnt_reg, cnt_next, cur_cnt;
    logic [bmpfb_pkg::HDR_CNT_W:0]   cnt_inc;
    logic [bmpfb_pkg::DIM_W-1:0]     width_reg, width_next, cur_w;
    logic [bmpfb_pkg::DIM_W-1:0]     height_reg, height_next, cur_h;
    logic [bmpfb_pkg::COL_W-1:0]     col_reg, col_next, cur_col, col_inc;
    logic [bmpfb_pkg::ROW_W-1:0]     row_reg, row_next, cur_row, row_inc;
    logic [bmpfb_pkg::BYTE_W-1:0]    held_blue_reg, held_blue_next;
    logic [bmpfb_pkg::BYTE_W-1:0]    held_green_reg, held_green_next;

    logic [1:0]                      w_lane, h_lane;
    logic signed [bmpfb_pkg::CHK_W-1:0] w_chk, h_chk, scr_w, scr_h;
    logic [bmpfb_pkg::ADDR_W-1:0]    row_a, col_a, addr;
    logic [bmpfb_pkg::BYTE_W-1:0]    b;

    assign b     = item.file_byte;
    assign scr_w = bmpfb_pkg::CHK_W'(bmpfb_pkg::SCREEN_WIDTH);
    assign scr_h = bmpfb_pkg::CHK_W'(bmpfb_pkg::SCREEN_HEIGHT);

    // a file start restarts parsing with this byte as byte zero
    always_comb begin
        if (item.file_start) begin
            cur_phase = bmpfb_pkg::PH_HEADER;
            cur_cnt   = '0;
            cur_w     = '0;
            cur_h     = '0;
            cur_col   = '0;
            cur_row   = '0;
            cur_trip  = bmpfb_pkg::TRIP_BLUE;
        end else begin
            cur_phase = phase_reg;
            cur_cnt   = cnt_reg;
            cur_w     = width_reg;
            cur_h     = height_reg;
            cur_col   = col_reg;
            cur_row   = row_reg;
            cur_trip  = trip_reg;
        end
    end

    assign w_lane  = 2'(cur_cnt - bmpfb_pkg::HDR_CNT_W'(bmpfb_pkg::WIDTH_LO));
    assign h_lane  = 2'(cur_cnt - bmpfb_pkg::HDR_CNT_W'(bmpfb_pkg::HEIGHT_LO));
    assign cnt_inc = {1'b0, cur_cnt} + (bmpfb_pkg::HDR_CNT_W+1)'(1);
    assign col_inc = cur_col + bmpfb_pkg::COL_W'(1);
    assign row_inc = cur_row + bmpfb_pkg::ROW_W'(1);

    // address arithmetic wraps at the address width
    assign row_a = cur_h[bmpfb_pkg::ADDR_W-1:0] - bmpfb_pkg::ADDR_W'(1)
                 - bmpfb_pkg::ADDR_W'(cur_row) + bmpfb_pkg::ADDR_W'(offsets.y_offset);
    assign col_a = bmpfb_pkg::ADDR_W'(cur_col) + bmpfb_pkg::ADDR_W'(offsets.x_offset);
    assign addr  = bmpfb_pkg::ADDR_W'(row_a * bmpfb_pkg::ADDR_W'(bmpfb_pkg::SCREEN_WIDTH))
                 + col_a;

    always_comb begin
        phase_next      = cur_phase;
        cnt_next        = cur_cnt;
        width_next      = cur_w;
        height_next     = cur_h;
        col_next        = cur_col;
        row_next        = cur_row;
        trip_next       = cur_trip;
        held_blue_next  = held_blue_reg;
        held_green_next = held_green_reg;
        w_chk           = '0;
        h_chk           = '0;
        res_valid       = 1'b0;
        res             = '0;
        unique case (cur_phase)
            bmpfb_pkg::PH_HEADER: begin
                if (cur_cnt >= bmpfb_pkg::HDR_CNT_W'(bmpfb_pkg::WIDTH_LO) &&
                    cur_cnt <  bmpfb_pkg::HDR_CNT_W'(bmpfb_pkg::HEIGHT_LO)) begin
                    width_next[{w_lane, 3'b000} +: 8] = b;
                end else if (cur_cnt >= bmpfb_pkg::HDR_CNT_W'(bmpfb_pkg::HEIGHT_LO) &&
                             cur_cnt <  bmpfb_pkg::HDR_CNT_W'(bmpfb_pkg::HEIGHT_LO + 4)) begin
                    height_next[{h_lane, 3'b000} +: 8] = b;
                end
                cnt_next = cnt_inc[bmpfb_pkg::HDR_CNT_W-1:0];
                w_chk = {{2{width_next[bmpfb_pkg::DIM_W-1]}}, width_next}
                      + bmpfb_pkg::CHK_W'(offsets.x_offset);
                h_chk = {{2{height_next[bmpfb_pkg::DIM_W-1]}}, height_next}
                      + bmpfb_pkg::CHK_W'(offsets.y_offset);
                if (cnt_inc == (bmpfb_pkg::HDR_CNT_W+1)'(bmpfb_pkg::HEADER_BYTES)) begin
                    if (w_chk > scr_w || h_chk > scr_h) begin
                        phase_next      = bmpfb_pkg::PH_DONE;
                        res_valid       = 1'b1;
                        res.result_kind = bmpfb_pkg::RK_RANGE;
                    end else if (width_next[bmpfb_pkg::DIM_W-1] || width_next == '0 ||
                                 height_next[bmpfb_pkg::DIM_W-1] || height_next == '0) begin
                        phase_next = bmpfb_pkg::PH_DONE;
                    end else begin
                        phase_next = bmpfb_pkg::PH_PIXELS;
                        col_next   = '0;
                        row_next   = '0;
                        trip_next  = bmpfb_pkg::TRIP_BLUE;
                    end
                end
            end
            bmpfb_pkg::PH_PIXELS: begin
                unique case (cur_trip)
                    bmpfb_pkg::TRIP_BLUE: begin
                        held_blue_next = b;
                        trip_next      = bmpfb_pkg::TRIP_GREEN;
                    end
                    bmpfb_pkg::TRIP_GREEN: begin
                        held_green_next = b;
                        trip_next       = bmpfb_pkg::TRIP_RED;
                    end
                    default: begin
                        trip_next         = bmpfb_pkg::TRIP_BLUE;
                        res_valid         = 1'b1;
                        res.result_kind   = bmpfb_pkg::RK_PIXEL;
                        res.pixel_address = addr;
                        res.pixel_color   = {b, held_green_reg, held_blue_reg};
                        col_next          = col_inc;
                        if (bmpfb_pkg::DIM_W'(col_inc) >= cur_w) begin
                            col_next = '0;
                            row_next = row_inc;
                            if (bmpfb_pkg::DIM_W'(row_inc) >= cur_h) begin
                                phase_next = bmpfb_pkg::PH_DONE;
                            end
                        end
                    end
                endcase
            end
            default: begin
                // idle or done: byte ignored
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= bmpfb_pkg::PH_IDLE;
            cnt_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            trip_reg   <= bmpfb_pkg::TRIP_BLUE;
        end else if (step) begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            trip_reg   <= trip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            held_blue_reg  <= held_blue_next;
            held_green_reg <= held_green_next;
        end
    end

    a_range_ends_file: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_valid && res.result_kind == bmpfb_pkg::RK_RANGE
        |=> phase_reg == bmpfb_pkg::PH_DONE)
        else $error("out-of-range request did not end the file");

    a_pixel_needs_pixel_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_valid && res.result_kind == bmpfb_pkg::RK_PIXEL
        |-> phase_reg == bmpfb_pkg::PH_PIXELS && !item.file_start)
        else $error("pixel request outside the pixel phase");

    a_column_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == bmpfb_pkg::PH_PIXELS
        |-> col_reg < bmpfb_pkg::COL_W'(bmpfb_pkg::SCREEN_WIDTH))
        else $error("column counter ran past the screen width");

endmodule

FILE: sim/tb_bmp24_framebuffer_blitter_unit.sv
module tb_bmp24_framebuffer_blitter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bmpfb_pkg::*;

    class blit_scoreboard;
        logic [XOFF_W-1:0] x_off;
        logic [YOFF_W-1:0] y_off;
        phase_t            phase;
        int                hdr_cnt;
        logic [31:0]       raw_w;
        logic [31:0]       raw_h;
        longint            pic_w;
        longint            pic_h;
        longint            col;
        longint            row;
        triple_t           trip;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        out_item_t         expected_writes[$];
        int                errors;

        function new();
            x_off   = '0;
            y_off   = '0;
            phase   = PH_IDLE;
            hdr_cnt = 0;
            raw_w   = '0;
            raw_h   = '0;
            pic_w   = 0;
            pic_h   = 0;
            col     = 0;
            row     = 0;
            trip    = TRIP_BLUE;
            blue    = '0;
            green   = '0;
            errors  = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] blitter mismatch: %s", $time, msg);
            errors++;
        endtask

        // works out what one accepted file byte should produce
        function void note_byte(input in_item_t req);
            longint wd;
            longint ht;
            longint addr;
            if (req.file_start) begin
                phase   = PH_HEADER;
                hdr_cnt = 0;
                raw_w   = '0;
                raw_h   = '0;
                col     = 0;
                row     = 0;
                trip    = TRIP_BLUE;
                blue    = '0;
                green   = '0;
            end
            case (phase)
                PH_HEADER: begin
                    if (hdr_cnt >= WIDTH_LO && hdr_cnt < WIDTH_LO + 4)
                        raw_w[8*(hdr_cnt-WIDTH_LO) +: 8] = req.file_byte;
                    else if (hdr_cnt >= HEIGHT_LO && hdr_cnt < HEIGHT_LO + 4)
                        raw_h[8*(hdr_cnt-HEIGHT_LO) +: 8] = req.file_byte;
                    hdr_cnt++;
                    if (hdr_cnt == HEADER_BYTES) begin
                        wd = longint'(raw_w);
                        ht = longint'(raw_h);
                        if (raw_w[31]) wd -= 64'sh1_0000_0000;
                        if (raw_h[31]) ht -= 64'sh1_0000_0000;
                        if (wd + longint'(x_off) > SCREEN_WIDTH ||
                            ht + longint'(y_off) > SCREEN_HEIGHT) begin
                            phase = PH_DONE;
                            expected_writes.push_back('{result_kind: RK_RANGE,
                                                        pixel_address: '0,
                                                        pixel_color: '0});
                        end else if (wd <= 0 || ht <= 0) begin
                            phase = PH_DONE;
                        end else begin
                            phase = PH_PIXELS;
                            pic_w = wd;
                            pic_h = ht;
                            col   = 0;
                            row   = 0;
                            trip  = TRIP_BLUE;
                        end
                    end
                end
                PH_PIXELS: begin
                    case (trip)
                        TRIP_BLUE: begin
                            blue = req.file_byte;
                            trip = TRIP_GREEN;
                        end
                        TRIP_GREEN: begin
                            green = req.file_byte;
                            trip  = TRIP_RED;
                        end
                        default: begin
                            trip = TRIP_BLUE;
                            // file rows run bottom-up
                            addr = (pic_h - 1 - row + longint'(y_off)) * SCREEN_WIDTH
                                   + col + longint'(x_off);
                            expected_writes.push_back('{result_kind: RK_PIXEL,
                                pixel_address: addr[ADDR_W-1:0],
                                pixel_color: {req.file_byte, green, blue}});
                            col++;
                            if (col >= pic_w) begin
                                col = 0;
                                row++;
                                if (row >= pic_h) phase = PH_DONE;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        endfunction

        task check_write(input out_item_t got);
            out_item_t want;
            if (expected_writes.size() == 0) begin
                report($sformatf("unexpected request kind %0d addr %0d colour %06h",
                                 got.result_kind, got.pixel_address, got.pixel_color));
            end else begin
                want = expected_writes.pop_front();
                if (got.result_kind !== want.result_kind)
                    report($sformatf("kind %0d, wanted %0d",
                                     got.result_kind, want.result_kind));
                if (got.pixel_address !== want.pixel_address)
                    report($sformatf("address %0d, wanted %0d",
                                     got.pixel_address, want.pixel_address));
                if (got.pixel_color !== want.pixel_color)
                    report($sformatf("colour %06h, wanted %06h",
                                     got.pixel_color, want.pixel_color));
            end
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    blit_scoreboard sb;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_cycles = 0;
    int byte_count  = 0;

    bmp24_framebuffer_blitter_unit u_dut (
        .aclk,
        .aresetn,
        .s_valid,
        .s_ready,
        .s_data,
        .m_valid,
        .m_ready,
        .m_data,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_data);
            if (m_valid && m_ready) sb.check_write(m_data);
        end
    end

    // result side: long hold-offs on request, random stalls otherwise
    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{file_byte: b, file_start: first};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // pix may be negative to cut the header short; fill < 0 gives random pixel bytes
    task automatic send_file(input logic [31:0] w, input logic [31:0] h, input int pix,
                             input int trail, input int fill);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < HEADER_BYTES + pix; i++) begin
            b = BYTE_W'($urandom);
            if (i >= WIDTH_LO && i < WIDTH_LO + 4)
                b = w[8*(i-WIDTH_LO) +: 8];
            else if (i >= HEIGHT_LO && i < HEIGHT_LO + 4)
                b = h[8*(i-HEIGHT_LO) +: 8];
            else if (i >= HEADER_BYTES && fill >= 0)
                b = fill[7:0];
            send_byte(b, i == 0);
        end
        byte_count += HEADER_BYTES + pix;
        repeat (trail) send_byte(BYTE_W'($urandom), 1'b0);
    endtask

    task automatic wait_until_flushed();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_writes.size() != 0) @(posedge aclk);
        // a header or ignored byte may still be in the pipe
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_offsets(input logic [CFG_DATA_W-1:0] xv,
                                 input logic [CFG_DATA_W-1:0] yv);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_X_OFFSET;
        cfg_data  <= xv;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_Y_OFFSET;
        cfg_data  <= yv;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.x_off = xv;
        sb.y_off = yv[YOFF_W-1:0];
    endtask

    // y keeps its low bits in range, the unused top bit is set now and then
    task automatic write_random_offsets();
        write_offsets(CFG_DATA_W'($urandom_range(0, SCREEN_WIDTH - 1)),
                      {1'($urandom_range(0, 7) == 0),
                       9'($urandom_range(0, SCREEN_HEIGHT - 1))});
    endtask

    task automatic random_file();
        int          kind;
        int          wmax;
        int          hmax;
        int          full;
        logic [31:0] w;
        logic [31:0] h;
        kind = $urandom_range(0, 99);
        wmax = SCREEN_WIDTH - int'(sb.x_off);
        hmax = SCREEN_HEIGHT - int'(sb.y_off);
        if (wmax < 1 || hmax < 1) begin
            kind = 70;
            wmax = 1;
            hmax = 1;
        end
        w    = $urandom_range(1, (wmax < 4) ? wmax : 4);
        h    = $urandom_range(1, (hmax < 3) ? hmax : 3);
        full = int'(w) * int'(h) * 3;
        if (kind < 60) begin
            send_file(w, h, full, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
                      -1);
        end else if (kind < 68) begin
            // cut short inside the pixels, next file start restarts
            send_file(w, h, $urandom_range(0, full - 1), 0, -1);
        end else if (kind < 80) begin
            case ($urandom_range(0, 2))
                0: w = wmax + $urandom_range(1, 4);
                1: h = hmax + $urandom_range(1, 4);
                default: begin
                    w = $urandom;
                    h = $urandom;
                end
            endcase
            send_file(w, h, $urandom_range(0, 6), 0, -1);
        end else if (kind < 92) begin
            case ($urandom_range(0, 3))
                0: w = '0;
                1: h = '0;
                2: w = {1'b1, 31'($urandom)};
                default: h = {1'b1, 31'($urandom)};
            endcase
            send_file(w, h, $urandom_range(0, 6), 0, -1);
        end else begin
            send_file($urandom, $urandom, -int'($urandom_range(1, 53)), 0, -1);
        end
    endtask

    initial begin : timeout
        #3_000_000;
        $display("bmp24_framebuffer_blitter_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int idle_by_phase[4]  = '{0, 60, 0, 16};
        int stall_by_phase[4] = '{0, 0, 60, 16};
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stray bytes before any file start
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(BYTE_W'($urandom), 1'b0);
        send_file(1, 1, 3, 0, 8'hFF);
        send_file(1, 1, 3, 3, 8'h00);
        send_file(3, 2, 18, 0, -1);
        // restart inside the header, then inside the pixels
        send_file(2, 2, -30, 0, -1);
        send_file(3, 3, 5, 0, -1);
        send_file(SCREEN_WIDTH + 1, 1, 3, 0, -1);
        send_file(1, SCREEN_HEIGHT + 1, 3, 0, -1);
        send_file(32'h7FFF_FFFF, 32'h7FFF_FFFF, 3, 0, -1);
        send_file(0, 2, 6, 0, -1);
        send_file(2, 32'hFFFF_FFFE, 6, 0, -1);
        send_file(32'h8000_0000, 32'h8000_0000, 3, 0, -1);

        // picture in the bottom right corner, exact fit and one past it
        wait_until_flushed();
        write_offsets(CFG_DATA_W'(SCREEN_WIDTH - 1), CFG_DATA_W'(SCREEN_HEIGHT - 1));
        send_file(1, 1, 3, 2, -1);
        send_file(2, 1, 6, 0, -1);
        send_file(1, 2, 6, 0, -1);
        send_file(32'hFFFF_FFFF, 1, 3, 0, -1);
        wait_until_flushed();
        write_offsets(10'h3FF, 10'h3FF);
        send_file(1, 1, 3, 0, -1);

        byte_count = 0;
        for (int ph = 0; ph < 4; ph++) begin
            wait_until_flushed();
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            case (ph)
                1: write_offsets(CFG_DATA_W'(SCREEN_WIDTH - 1),
                                 CFG_DATA_W'(SCREEN_HEIGHT - 1));
                2: write_offsets('0, '0);
                default: write_random_offsets();
            endcase
            // sender keeps going so the block fills up and stalls
            hold_cycles = 200;
            while (byte_count < 450 * (ph + 1)) begin
                random_file();
                if ($urandom_range(0, 9) == 0) begin
                    wait_until_flushed();
                    write_random_offsets();
                end else if ($urandom_range(0, 14) == 0) begin
                    hold_cycles = 300;
                end
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        for (int k = 0; k < 5000 && sb.expected_writes.size() != 0; k++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.expected_writes.size() != 0)
            sb.report($sformatf("%0d requests never came", sb.expected_writes.size()));
        if (sb.errors == 0)
            $display("bmp24_framebuffer_blitter_unit regression: pass");
        else
            $display("bmp24_framebuffer_blitter_unit regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bmpfb_pkg.sv
rtl/core/bmpfb_cfg.sv
rtl/core/bmpfb_core.sv
rtl/core/bmp24_framebuffer_blitter_unit.sv
sim/tb_bmp24_framebuffer_blitter_unit.sv
